// File: src/ptl_pkg.sv
// shared constants for the two-level page table with lru frame ring
// no dependencies; imported by the interfaces and the top level

package ptl_pkg;

	// default geometry, handed to the top level parameters
	localparam int PROCS_DEF      = 4;
	localparam int VADDR_BITS_DEF = 24;
	localparam int PAGE_BITS_DEF  = 12;
	localparam int FRAMES_DEF     = 64;

	// fixed field widths of the channels
	localparam int PID_IN_W = 2;
	localparam int VA_IN_W  = 24;
	localparam int PA_W     = 18;

	// first-level split register
	localparam int              FLB_W     = 4;
	localparam logic [FLB_W-1:0] FLB_RESET = 4'd6;

endpackage

// File: src/ptl_if.sv
// request and result channels of the page table block
// depends on ptl_pkg for the field widths

interface ptl_req_if import ptl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PID_IN_W-1:0] process_id;
	logic [VA_IN_W-1:0]  virtual_address;

	modport source (output valid, process_id, virtual_address, input ready);
	modport sink (input valid, process_id, virtual_address, output ready);
endinterface

interface ptl_rsp_if import ptl_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PA_W-1:0] physical_address;
	logic            page_hit;
	logic            table_created;

	modport source (output valid, physical_address, page_hit, table_created, input ready);
	modport sink (input valid, physical_address, page_hit, table_created, output ready);
endinterface

// File: src/ptl_ram.sv
// single write port, single read port synchronous memory, registered read
// no dependencies

module ptl_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/ptl_clear.sv
// reset sweep counter: walks every memory index once after reset
// no dependencies

module ptl_clear #(
	parameter int COUNT = 16384,
	parameter int CW    = 14
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          active,
	output logic [CW-1:0] idx
);

	logic          active_q;
	logic [CW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			if (idx_q == CW'(COUNT - 1)) begin
				active_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	assign active = active_q;
	assign idx    = idx_q;

endmodule

// File: src/two_level_page_table_lru.sv
// two-level page table translation with an lru frame ring
// request walk: lookup, read, then a fault write, a finish on a hit of the oldest frame, or
// a relink (link read, two link writes, as each ring memory has a single write port)
// one request at a time: a new one is taken only after the previous result is loaded
// reset: a sweep of all max(entries, frames) indices (16384 by default) clears all memories;
// requests are held off until it ends, configuration writes are taken at any time
// depends on ptl_pkg, ptl_if, ptl_ram, ptl_clear

module two_level_page_table_lru import ptl_pkg::*; #(
	parameter int PROCS      = PROCS_DEF,
	parameter int VADDR_BITS = VADDR_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int FRAMES     = FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	ptl_req_if.sink          req,
	ptl_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [FLB_W-1:0] cfg_wdata
);

	localparam int VPN_BITS    = VADDR_BITS - PAGE_BITS;
	localparam int PID_W       = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int FRAME_W     = $clog2(FRAMES);
	localparam int ENTRY_COUNT = PROCS * (2 ** VPN_BITS);
	localparam int ENTRY_AW    = PID_W + VPN_BITS;
	localparam int TABLE_COUNT = PROCS * (2 ** (VPN_BITS - 1));
	localparam int TABLE_AW    = PID_W + VPN_BITS - 1;
	localparam int OWN_W       = 1 + PID_W + VPN_BITS;
	localparam int CLR_COUNT   = (ENTRY_COUNT > FRAMES) ? ENTRY_COUNT : FRAMES;
	localparam int CLR_W       = $clog2(CLR_COUNT);
	localparam int SH_W        = $clog2(VPN_BITS + 1);
	localparam int FL_MAX      = VPN_BITS - 1;
	localparam int PA_FULL_W   = PA_W + FRAME_W + PAGE_BITS;

	// one-hot sequencer states
	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LOOK    = 8'b0000_0010,
		S_READ    = 8'b0000_0100,
		S_FAULT   = 8'b0000_1000,
		S_LINK_RD = 8'b0001_0000,
		S_LINK_A  = 8'b0010_0000,
		S_LINK_B  = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	// process id folded into the table range
	function automatic logic [PID_W-1:0] pid_mod(input logic [PID_IN_W-1:0] p);
		logic [PID_IN_W-1:0] v;
		v = p;
		for (int i = 0; i < (1 << PID_IN_W) - 1; i++) begin
			if (int'(v) >= PROCS) begin
				v = PID_IN_W'(int'(v) - PROCS);
			end
		end
		return PID_W'(v);
	endfunction

	state_t state_q, state_d;

	logic [FLB_W-1:0]     flb_q;
	logic [FRAME_W-1:0]   oldest_q;

	// request context held for the whole walk
	logic [PID_W-1:0]     pid_q;
	logic [VPN_BITS-1:0]  vpn_q;
	logic [PAGE_BITS-1:0] off_q;
	logic [ENTRY_AW-1:0]  eix_q;
	logic [TABLE_AW-1:0]  tix_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [FRAME_W-1:0]   nf_q;
	logic                 hit_q;
	logic                 created_q;

	// result register
	logic                 rsp_valid_q;
	logic [PA_W-1:0]      rsp_pa_q;
	logic                 rsp_hit_q;
	logic                 rsp_created_q;

	// request decode
	logic [VADDR_BITS-1:0] va_in;
	logic [VPN_BITS-1:0]   vpn_in;
	logic [PAGE_BITS-1:0]  off_in;
	logic [PID_W-1:0]      pid_in;
	logic [FLB_W-1:0]      fl_eff;
	logic [SH_W-1:0]       sh;
	logic [VPN_BITS-1:0]   top_in;
	logic [ENTRY_AW-1:0]   eix_in;
	logic [TABLE_AW-1:0]   tix_in;

	// memory ports
	logic                ent_we;
	logic [ENTRY_AW-1:0] ent_waddr, ent_raddr;
	logic [FRAME_W:0]    ent_wdata, ent_rdata;
	logic                tbl_we;
	logic [TABLE_AW-1:0] tbl_waddr, tbl_raddr;
	logic [0:0]          tbl_wdata, tbl_rdata;
	logic                own_we;
	logic [FRAME_W-1:0]  own_waddr, own_raddr;
	logic [OWN_W-1:0]    own_wdata, own_rdata;
	logic                nxt_we;
	logic [FRAME_W-1:0]  nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
	logic                prv_we;
	logic [FRAME_W-1:0]  prv_waddr, prv_raddr, prv_wdata, prv_rdata;

	logic                clr_active;
	logic [CLR_W-1:0]    clr_idx;

	logic                accept;
	logic                load_rsp;
	logic                look_hit;
	logic [FRAME_W-1:0]  look_frame;
	logic                own_valid;
	logic [PID_W-1:0]    own_pid;
	logic [VPN_BITS-1:0] own_page;
	logic [PA_FULL_W-1:0] pa_full;

	// ---- split of the page number ----
	assign va_in  = VADDR_BITS'(req.virtual_address);
	assign vpn_in = va_in[VADDR_BITS-1:PAGE_BITS];
	assign off_in = va_in[PAGE_BITS-1:0];
	assign pid_in = pid_mod(req.process_id);

	// first-level width saturates to one below the page-number width; zero reads as one
	always_comb begin
		fl_eff = flb_q;
		if (flb_q == '0) begin
			fl_eff = FLB_W'(1);
		end else if (int'(flb_q) > FL_MAX) begin
			fl_eff = FLB_W'(FL_MAX);
		end
	end

	assign sh     = SH_W'(VPN_BITS) - SH_W'(fl_eff);
	assign top_in = vpn_in >> sh;
	assign eix_in = {pid_in, vpn_in};
	assign tix_in = {pid_in, top_in[VPN_BITS-2:0]};

	// ---- handshake ----
	assign req.ready = (state_q == S_IDLE) && !clr_active;
	assign accept    = req.valid && req.ready;
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// frame picked in the lookup cycle: the mapped frame on a hit, the oldest on a fault
	assign look_hit   = ent_rdata[FRAME_W];
	assign look_frame = look_hit ? ent_rdata[FRAME_W-1:0] : oldest_q;

	assign own_valid = own_rdata[OWN_W-1];
	assign own_pid   = own_rdata[OWN_W-2:VPN_BITS];
	assign own_page  = own_rdata[VPN_BITS-1:0];

	// ---- sequencer and memory port control ----
	always_comb begin
		state_d = state_q;

		ent_we    = 1'b0;
		ent_waddr = eix_q;
		ent_wdata = '0;
		ent_raddr = eix_in;

		tbl_we    = 1'b0;
		tbl_waddr = tix_q;
		tbl_wdata = 1'b1;
		tbl_raddr = tix_in;

		own_we    = 1'b0;
		own_waddr = frame_q;
		own_wdata = {1'b1, pid_q, vpn_q};
		own_raddr = look_frame;

		nxt_we    = 1'b0;
		nxt_waddr = frame_q;
		nxt_wdata = oldest_q;
		nxt_raddr = look_frame;

		prv_we    = 1'b0;
		prv_waddr = frame_q;
		prv_wdata = oldest_q;
		prv_raddr = (state_q == S_LINK_RD) ? oldest_q : look_frame;

		if (clr_active) begin
			// reset sweep: every store back to its reset contents
			ent_we    = (int'(clr_idx) < ENTRY_COUNT);
			ent_waddr = ENTRY_AW'(clr_idx);
			ent_wdata = '0;
			tbl_we    = (int'(clr_idx) < TABLE_COUNT);
			tbl_waddr = TABLE_AW'(clr_idx);
			tbl_wdata = 1'b0;
			own_we    = (int'(clr_idx) < FRAMES);
			own_waddr = FRAME_W'(clr_idx);
			own_wdata = '0;
			nxt_we    = (int'(clr_idx) < FRAMES);
			nxt_waddr = FRAME_W'(clr_idx);
			nxt_wdata = (int'(clr_idx) == FRAMES - 1) ? '0 : FRAME_W'(clr_idx + 1'b1);
			prv_we    = (int'(clr_idx) < FRAMES);
			prv_waddr = FRAME_W'(clr_idx);
			prv_wdata = (clr_idx == '0) ? FRAME_W'(FRAMES - 1) : FRAME_W'(clr_idx - 1'b1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_d = S_LOOK;
					end
				end
				S_LOOK: begin
					// mark the second-level table as in use
					tbl_we  = 1'b1;
					state_d = S_READ;
				end
				S_READ: begin
					if (!hit_q) begin
						// fault: drop the previous owner's mapping first
						if (own_valid) begin
							ent_we    = 1'b1;
							ent_waddr = {own_pid, own_page};
							ent_wdata = '0;
						end
						state_d = S_FAULT;
					end else if (frame_q == oldest_q) begin
						state_d = S_DONE;
					end else begin
						// unlink the hit frame from the ring
						nxt_we    = 1'b1;
						nxt_waddr = prv_rdata;
						nxt_wdata = nxt_rdata;
						prv_we    = 1'b1;
						prv_waddr = nxt_rdata;
						prv_wdata = prv_rdata;
						state_d   = S_LINK_RD;
					end
				end
				S_FAULT: begin
					ent_we    = 1'b1;
					ent_waddr = eix_q;
					ent_wdata = {1'b1, frame_q};
					own_we    = 1'b1;
					state_d   = S_DONE;
				end
				S_LINK_RD: begin
					state_d = S_LINK_A;
				end
				S_LINK_A: begin
					// splice in after the newest frame
					nxt_we    = 1'b1;
					nxt_waddr = prv_rdata;
					nxt_wdata = frame_q;
					prv_we    = 1'b1;
					prv_waddr = frame_q;
					prv_wdata = prv_rdata;
					state_d   = S_LINK_B;
				end
				S_LINK_B: begin
					prv_we    = 1'b1;
					prv_waddr = oldest_q;
					prv_wdata = frame_q;
					nxt_we    = 1'b1;
					nxt_waddr = frame_q;
					nxt_wdata = oldest_q;
					state_d   = S_DONE;
				end
				S_DONE: begin
					if (load_rsp) begin
						state_d = S_IDLE;
					end
				end
				default: begin
					state_d = S_IDLE;
				end
			endcase
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			flb_q       <= FLB_RESET;
			oldest_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				flb_q <= cfg_wdata;
			end
			// oldest pointer advances on a fault and on a hit of the oldest frame
			if (state_q == S_READ && hit_q && frame_q == oldest_q) begin
				oldest_q <= nxt_rdata;
			end else if (state_q == S_FAULT) begin
				oldest_q <= nf_q;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ---- request context and result payload ----
	always_ff @(posedge clk) begin
		if (accept) begin
			pid_q <= pid_in;
			vpn_q <= vpn_in;
			off_q <= off_in;
			eix_q <= eix_in;
			tix_q <= tix_in;
		end
		if (state_q == S_LOOK) begin
			hit_q     <= look_hit;
			frame_q   <= look_frame;
			created_q <= !tbl_rdata[0];
		end
		if (state_q == S_READ) begin
			nf_q <= nxt_rdata;
		end
		if (load_rsp) begin
			rsp_pa_q      <= pa_full[PA_W-1:0];
			rsp_hit_q     <= hit_q;
			rsp_created_q <= created_q;
		end
	end

	assign pa_full = {{PA_W{1'b0}}, frame_q, off_q};

	assign rsp.valid            = rsp_valid_q;
	assign rsp.physical_address = rsp_pa_q;
	assign rsp.page_hit         = rsp_hit_q;
	assign rsp.table_created    = rsp_created_q;

	// ---- memories ----
	ptl_clear #(.COUNT(CLR_COUNT), .CW(CLR_W)) u_clear (
		.clk(clk), .arst_n(arst_n), .active(clr_active), .idx(clr_idx)
	);

	// page table entries: valid bit and frame
	ptl_ram #(.DEPTH(ENTRY_COUNT), .AW(ENTRY_AW), .WIDTH(FRAME_W + 1)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.raddr(ent_raddr), .rdata(ent_rdata)
	);

	// second-level table present bits
	ptl_ram #(.DEPTH(TABLE_COUNT), .AW(TABLE_AW), .WIDTH(1)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	// frame owner: owned flag, process, page
	ptl_ram #(.DEPTH(FRAMES), .AW(FRAME_W), .WIDTH(OWN_W)) u_own (
		.clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
		.raddr(own_raddr), .rdata(own_rdata)
	);

	// lru ring links
	ptl_ram #(.DEPTH(FRAMES), .AW(FRAME_W), .WIDTH(FRAME_W)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(nxt_raddr), .rdata(nxt_rdata)
	);

	ptl_ram #(.DEPTH(FRAMES), .AW(FRAME_W), .WIDTH(FRAME_W)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(prv_raddr), .rdata(prv_rdata)
	);

	// ---- assertions ----
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !clr_active)
		else $error("request taken during reset sweep");

	a_oldest_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> $stable(oldest_q))
		else $error("oldest pointer moved with no request in flight");

	a_done_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp.ready) |=> (state_q == S_DONE))
		else $error("result dropped while output register was full");

endmodule

// File: dv/testbench.sv
// testbench for the two-level page table with lru frame ring
// depends on ptl_pkg, ptl_if and the two_level_page_table_lru rtl

module testbench;
	import ptl_pkg::*;

	localparam int VPN_W      = VADDR_BITS_DEF - PAGE_BITS_DEF;
	localparam int N_FRAMES   = FRAMES_DEF;
	localparam int WATCHDOG   = 80000;
	localparam int DRAIN_WAIT = 20;

	typedef struct packed {
		logic [PA_W-1:0] physical_address;
		logic            page_hit;
		logic            table_created;
	} xlate_t;

	// directed row: request, plus an optional hand-typed result
	typedef struct {
		logic [PID_IN_W-1:0] pid;
		logic [VA_IN_W-1:0]  va;
		bit                  typed;
		xlate_t              want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [FLB_W-1:0] cfg_wdata;

	ptl_req_if req_ch ();
	ptl_rsp_if rsp_ch ();

	two_level_page_table_lru u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state, one copy of every store
	bit                  pt_valid [4 << VPN_W];
	logic [5:0]          pt_frame [4 << VPN_W];
	bit                  pt_l2_present [4 << (VPN_W - 1)];
	bit                  fr_owned [N_FRAMES];
	logic [1:0]          fr_pid [N_FRAMES];
	logic [VPN_W-1:0]    fr_vpn [N_FRAMES];
	logic [5:0]          lru_next [N_FRAMES];
	logic [5:0]          lru_prev [N_FRAMES];
	logic [5:0]          lru_oldest;
	logic [FLB_W-1:0]    split_reg;

	xlate_t pending_xlates [$];
	int     send_idle_pct;
	int     recv_stall_pct;
	int     mismatches;
	int     quiet_cycles;
	bit     timed_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void lru_reset();
		for (int i = 0; i < N_FRAMES; i++) begin
			lru_next[i] = 6'((i + 1) % N_FRAMES);
			lru_prev[i] = 6'((i + N_FRAMES - 1) % N_FRAMES);
			fr_owned[i] = 1'b0;
		end
		lru_oldest = '0;
		foreach (pt_valid[i]) pt_valid[i] = 1'b0;
		foreach (pt_l2_present[i]) pt_l2_present[i] = 1'b0;
		split_reg = FLB_RESET;
	endfunction

	// translate one access and update tables and ring
	function automatic xlate_t translate(logic [1:0] pid, logic [VA_IN_W-1:0] va);
		int unsigned vpn, top, fl, tix, eix, f, p, n, vix;
		xlate_t r;
		vpn = va >> PAGE_BITS_DEF;
		fl  = split_reg;
		if (fl < 1) fl = 1;
		if (fl > VPN_W - 1) fl = VPN_W - 1;
		top = vpn >> (VPN_W - fl);
		tix = (pid << (VPN_W - 1)) + top;
		eix = (pid << VPN_W) | vpn;
		r.table_created = !pt_l2_present[tix];
		pt_l2_present[tix] = 1'b1;
		if (pt_valid[eix]) begin
			r.page_hit = 1'b1;
			f = pt_frame[eix];
			if (f == lru_oldest) begin
				lru_oldest = lru_next[f];
			end else begin
				// unlink, then splice in just before the oldest frame
				p = lru_prev[f];
				n = lru_next[f];
				lru_next[p] = 6'(n);
				lru_prev[n] = 6'(p);
				p = lru_prev[lru_oldest];
				lru_next[p] = 6'(f);
				lru_prev[f] = 6'(p);
				lru_prev[lru_oldest] = 6'(f);
				lru_next[f] = lru_oldest;
			end
		end else begin
			r.page_hit = 1'b0;
			f = lru_oldest;
			if (fr_owned[f]) begin
				vix = (fr_pid[f] << VPN_W) | fr_vpn[f];
				pt_valid[vix] = 1'b0;
			end
			pt_valid[eix] = 1'b1;
			pt_frame[eix] = 6'(f);
			fr_owned[f]   = 1'b1;
			fr_pid[f]     = pid;
			fr_vpn[f]     = VPN_W'(vpn);
			lru_oldest    = lru_next[f];
		end
		r.physical_address = PA_W'((f << PAGE_BITS_DEF) | (va & 24'hfff));
		return r;
	endfunction

	// hand one request to the block, waiting out the handshake;
	// valid stays up afterwards so back-to-back requests need no gap
	task automatic send_request(logic [1:0] pid, logic [VA_IN_W-1:0] va);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.process_id      <= pid;
		req_ch.virtual_address <= va;
		do @(posedge clk); while (!req_ch.ready);
		pending_xlates.push_back(translate(pid, va));
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_xlates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_split(logic [FLB_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		split_reg = v;
	endtask

	// random accesses: mostly a small working set so hits, relinks and
	// evictions all happen, with some far-flung addresses mixed in
	task automatic random_phase(int count, int idle, int stall);
		logic [1:0]  pid;
		logic [23:0] va;
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			pid = 2'($urandom_range(3));
			va  = 24'($urandom);
			if ($urandom_range(99) < 75)
				va[23:12] = {1'($urandom_range(1)), 5'b0, 6'($urandom_range(40))};
			send_request(pid, va);
		end
		drain();
	endtask

	// result check and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_xlates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result pa=%h hit=%b new=%b",
							rsp_ch.physical_address, rsp_ch.page_hit,
							rsp_ch.table_created);
				end else begin
					xlate_t w;
					w = pending_xlates.pop_front();
					if (w.physical_address !== rsp_ch.physical_address ||
					    w.page_hit !== rsp_ch.page_hit ||
					    w.table_created !== rsp_ch.table_created) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want pa=%h hit=%b new=%b got pa=%h hit=%b new=%b",
								w.physical_address, w.page_hit, w.table_created,
								rsp_ch.physical_address, rsp_ch.page_hit,
								rsp_ch.table_created);
					end
				end
			end
			rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog over cycles with no handshake; the reset sweep sits inside the limit
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.process_id = '0;
		req_ch.virtual_address = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		lru_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: first access faults into frame 0 with a new table
		rw = '{2'd0, 24'h000000, 1, '{18'h00000, 1'b0, 1'b1}}; rows.push_back(rw);
		rw = '{2'd0, 24'h000fff, 1, '{18'h00fff, 1'b1, 1'b0}}; rows.push_back(rw);
		rw = '{2'd3, 24'hffffff, 1, '{18'h01fff, 1'b0, 1'b1}}; rows.push_back(rw);
		rw = '{2'd1, 24'h000abc, 1, '{18'h02abc, 1'b0, 1'b1}}; rows.push_back(rw);
		// same page in another process is separate, hits on non-oldest frames relink
		rw = '{2'd2, 24'hffffff, 0, '0}; rows.push_back(rw);
		rw = '{2'd3, 24'hfff123, 0, '0}; rows.push_back(rw);
		rw = '{2'd0, 24'h555555, 0, '0}; rows.push_back(rw);
		rw = '{2'd1, 24'haaaaaa, 0, '0}; rows.push_back(rw);
		rw = '{2'd0, 24'h000321, 0, '0}; rows.push_back(rw);
		rw = '{2'd1, 24'h800000, 0, '0}; rows.push_back(rw);
		rw = '{2'd2, 24'h7fffff, 0, '0}; rows.push_back(rw);
		foreach (rows[i]) begin
			send_request(rows[i].pid, rows[i].va);
			if (rows[i].typed && pending_xlates[$] != rows[i].want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: want pa=%h hit=%b new=%b got pa=%h hit=%b new=%b",
						i, rows[i].want.physical_address, rows[i].want.page_hit,
						rows[i].want.table_created,
						pending_xlates[$].physical_address, pending_xlates[$].page_hit,
						pending_xlates[$].table_created);
			end
		end
		drain();
		// split extremes: 0 and 15 saturate; cycle through 70 distinct pages
		// to force evictions of the oldest frames
		write_split(4'd0);
		for (int i = 0; i < 70; i++) send_request(2'(i), {12'(i * 37), 12'(i)});
		drain();
		write_split(4'd15);
		for (int i = 0; i < 8; i++) send_request(2'(i), {12'(i * 37), 12'hfff});
		drain();

		write_split(4'd11);
		random_phase(250, 0, 0);
		write_split(4'd1);
		random_phase(250, 50, 0);
		write_split(4'($urandom_range(15)));
		random_phase(250, 0, 50);
		write_split(4'd6);
		random_phase(250, 16, 16);

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// File: sim.f
src/ptl_pkg.sv
src/ptl_if.sv
src/ptl_ram.sv
src/ptl_clear.sv
src/two_level_page_table_lru.sv
dv/testbench.sv
